@@ src/mfc_pkg.sv @@
`timescale 1ns / 1ps
// package for multi_mode_frame_check: payload structs, mode codes, start values
// no dependencies
package mfc_pkg;

	localparam logic [1:0] MODE_SUM   = 2'd0;
	localparam logic [1:0] MODE_CRC8  = 2'd1;
	localparam logic [1:0] MODE_CRC16 = 2'd2;
	localparam logic [1:0] MODE_CRC32 = 2'd3;

	localparam logic [7:0]  CRC8_POLY_REFL  = 8'h8C;
	localparam logic [31:0] CRC32_POLY_REFL = 32'hEDB88320;
	localparam logic [31:0] CRC32_INIT      = 32'hFFFFFFFF;
	localparam logic [31:0] CRC32_XOROUT    = 32'hFFFFFFFF;
	localparam logic [15:0] CRC16_INIT      = 16'h0000;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] check_value;
		logic [2:0]  check_bytes;
	} out_item_t;

	function automatic logic [31:0] start_value(input logic [1:0] mode);
		logic [31:0] v;
		case (mode)
			MODE_CRC32: v = CRC32_INIT;
			MODE_CRC16: v = {16'h0000, CRC16_INIT};
			default:    v = 32'h0000_0000;
		endcase
		return v;
	endfunction

endpackage

@@ src/mfc_fold.sv @@
`timescale 1ns / 1ps
// byte fold for all four check modes plus result formatting on the last byte
// depends on mfc_pkg
module mfc_fold (
	input  logic [1:0]        mode,
	input  logic [31:0]       running,
	input  mfc_pkg::in_item_t item,
	output logic [31:0]       running_next,
	output mfc_pkg::out_item_t result
);

	logic [7:0]  sum8;
	logic [7:0]  crc8;
	logic [15:0] crc16;
	logic [7:0]  x16;
	logic [31:0] crc32;
	logic [31:0] folded;

	// bit loops unroll into xor networks, eight narrow steps each
	always_comb begin
		sum8 = running[7:0] + item.data_byte;

		crc8 = running[7:0] ^ item.data_byte;
		for (int k = 0; k < 8; k++) begin
			crc8 = crc8[0] ? ((crc8 >> 1) ^ mfc_pkg::CRC8_POLY_REFL) : (crc8 >> 1);
		end

		x16 = running[15:8] ^ item.data_byte;
		x16 = x16 ^ (x16 >> 4);
		crc16 = {running[7:0], 8'h00} ^ {x16[3:0], 12'h000} ^ {3'b000, x16, 5'b00000}
			^ {8'h00, x16};

		crc32 = running ^ {24'h000000, item.data_byte};
		for (int k = 0; k < 8; k++) begin
			crc32 = crc32[0] ? ((crc32 >> 1) ^ mfc_pkg::CRC32_POLY_REFL) : (crc32 >> 1);
		end
	end

	always_comb begin
		case (mode)
			mfc_pkg::MODE_SUM: begin
				folded = {24'h000000, sum8};
				result.check_value = {24'h000000, sum8};
				result.check_bytes = 3'd1;
			end
			mfc_pkg::MODE_CRC8: begin
				folded = {24'h000000, crc8};
				result.check_value = {24'h000000, crc8};
				result.check_bytes = 3'd1;
			end
			mfc_pkg::MODE_CRC16: begin
				folded = {16'h0000, crc16};
				result.check_value = {16'h0000, crc16};
				result.check_bytes = 3'd2;
			end
			default: begin
				folded = crc32;
				result.check_value = crc32 ^ mfc_pkg::CRC32_XOROUT;
				result.check_bytes = 3'd4;
			end
		endcase
		// a frame's last byte restarts the running value
		running_next = item.last_byte ? mfc_pkg::start_value(mode) : folded;
	end

endmodule

@@ src/multi_mode_frame_check.sv @@
`timescale 1ns / 1ps
// Running frame check over a byte stream: additive checksum, reflected CRC-8 (poly 0x8C),
// CRC-16 XMODEM or reflected CRC-32, chosen by a 2-bit mode register. One byte is taken
// every clock cycle unless in_stall is high; a byte passes an input register, the
// combinational byte fold (unrolled eight-step xor networks for CRC-8 and CRC-32) and a
// result register, from which the result is offered. Only a byte flagged as last yields a
// result transaction, carrying the finished check (final xor applied, right aligned) and its byte
// count. Writing the mode register restarts the running value at the new mode's start value.
// depends on mfc_pkg and mfc_fold
module multi_mode_frame_check (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mfc_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output mfc_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_data
);

	logic               valid_s1;
	mfc_pkg::in_item_t  item_s1;
	logic [1:0]         mode_q;
	logic [31:0]        running_q;
	logic [31:0]        running_next;
	mfc_pkg::out_item_t result;
	logic               out_valid_q;
	mfc_pkg::out_item_t out_data_q;
	logic               advance;

	// result register free or being emptied this cycle
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	mfc_fold u_fold (
		.mode         (mode_q),
		.running      (running_q),
		.item         (item_s1),
		.running_next (running_next),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= mfc_pkg::MODE_SUM;
			running_q <= mfc_pkg::start_value(mfc_pkg::MODE_SUM);
		end else if (cfg_we) begin
			mode_q    <= cfg_data;
			running_q <= mfc_pkg::start_value(cfg_data);
		end else if (valid_s1 && advance) begin
			running_q <= running_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && item_s1.last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && item_s1.last_byte) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ src/mfc_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for multi_mode_frame_check and the bind that attaches them
// depends on mfc_pkg and multi_mode_frame_check
module mfc_port_props (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input mfc_pkg::out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_bytes_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.check_bytes == 3'd1 || out_data.check_bytes == 3'd2
			|| out_data.check_bytes == 3'd4)
		else $error("illegal check byte count");

	a_one_byte_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.check_bytes == 3'd1 |-> out_data.check_value[31:8] == 24'h0)
		else $error("one-byte check has high bits set");

	a_two_byte_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.check_bytes == 3'd2 |-> out_data.check_value[31:16] == 16'h0)
		else $error("two-byte check has high bits set");

endmodule

bind multi_mode_frame_check mfc_port_props u_mfc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
